[rtl/core/mlrt_pkg.sv]
`default_nettype none

package mlrt_pkg;

  // Widest lane count the ports can carry.
  localparam int MAX_LANES = 4;

  // Race phase codes.
  localparam logic [1:0] PHASE_IDLE     = 2'd0;
  localparam logic [1:0] PHASE_RUNNING  = 2'd1;
  localparam logic [1:0] PHASE_FINISHED = 2'd2;

  // Event kind codes.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_RESET  = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  // Input action codes.
  localparam logic ACTION_POLL = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [7:0] CFG_BUTTON_POL = 8'd0;
  localparam logic [7:0] CFG_FINISH_POL = 8'd1;

  // A history that reads exactly this value marks a press or a finish.
  localparam logic [7:0] HIST_HIT = 8'h01;

  // Place counter value once all places are handed out.
  localparam logic [2:0] NO_PLACE_LEFT = 3'd5;
  localparam logic [2:0] FIRST_PLACE   = 3'd1;
  localparam logic [2:0] LAST_PLACE    = 3'd4;

  // Bit positions in the per-item event set.
  localparam int EV_START = 0;
  localparam int EV_RESET = 1;
  localparam int EV_LANE0 = 2;
  localparam int EV_W     = EV_LANE0 + MAX_LANES;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // One classified item: the events it raised and the state after it.
  typedef struct packed {
    logic                   start_ev;
    logic                   reset_ev;
    logic [MAX_LANES-1:0]   fin_set;
    logic [1:0]             phase;
    logic [MAX_LANES-1:0]   mask;
    logic [3*MAX_LANES-1:0] places;
    logic [16*MAX_LANES-1:0] times;
  } mlrt_rec_t;

endpackage

`default_nettype wire

[rtl/core/mlrt_front.sv]
`default_nettype none

module mlrt_front import mlrt_pkg::*; #(
  parameter int LANE_COUNT = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 action,
  input  wire logic                 start_level,
  input  wire logic                 reset_level,
  input  wire logic [MAX_LANES-1:0] finish_levels,
  input  wire logic                 cfg_valid,
  input  wire logic [7:0]           cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 queue_full,
  output logic                      push,
  output mlrt_rec_t                 push_rec
);

  localparam logic [MAX_LANES-1:0] LANE_EN = MAX_LANES'((1 << LANE_COUNT) - 1);

  logic btn_pol_high;
  logic finish_active_high;

  logic [1:0]           phase;
  logic [15:0]          lane_ms    [MAX_LANES];
  logic [MAX_LANES-1:0] lane_active;
  logic [2:0]           lane_place [MAX_LANES];
  logic [2:0]           next_place;
  logic [7:0]           start_history;
  logic [7:0]           reset_history;
  logic [7:0]           finish_history [MAX_LANES];

  logic [1:0]           phase_next;
  logic [15:0]          lane_ms_next    [MAX_LANES];
  logic [MAX_LANES-1:0] lane_active_next;
  logic [2:0]           lane_place_next [MAX_LANES];
  logic [2:0]           next_place_next;
  logic [7:0]           start_history_next;
  logic [7:0]           reset_history_next;
  logic [7:0]           finish_history_next [MAX_LANES];

  logic                 start_hit;
  logic                 reset_hit;
  logic [MAX_LANES-1:0] fin_set;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      btn_pol_high       <= 1'b0;
      finish_active_high <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BUTTON_POL) begin
        btn_pol_high <= cfg_data[0];
      end else if (cfg_index == CFG_FINISH_POL) begin
        finish_active_high <= cfg_data[0];
      end
    end
  end

  always_comb begin
    logic s;
    logic r;
    logic a;
    phase_next         = phase;
    lane_active_next   = lane_active;
    next_place_next    = next_place;
    start_history_next = start_history;
    reset_history_next = reset_history;
    for (int i = 0; i < MAX_LANES; i++) begin
      lane_ms_next[i]        = lane_ms[i];
      lane_place_next[i]     = lane_place[i];
      finish_history_next[i] = finish_history[i];
    end
    start_hit = 1'b0;
    reset_hit = 1'b0;
    fin_set   = '0;
    s = start_level ^ !btn_pol_high;
    r = reset_level ^ !btn_pol_high;
    a = 1'b0;

    if (action == ACTION_TICK) begin
      if (phase == PHASE_RUNNING) begin
        for (int i = 0; i < MAX_LANES; i++) begin
          if (LANE_EN[i] && lane_active[i]) begin
            lane_ms_next[i] = lane_ms[i] + 16'd1;
          end
        end
      end
    end else begin
      start_history_next = {start_history[6:0], s};
      if (start_history_next == HIST_HIT &&
          (phase == PHASE_IDLE || phase == PHASE_FINISHED)) begin
        start_hit = 1'b1;
        for (int i = 0; i < MAX_LANES; i++) begin
          lane_ms_next[i]    = '0;
          lane_place_next[i] = '0;
        end
        lane_active_next = LANE_EN;
        next_place_next  = FIRST_PLACE;
        phase_next       = PHASE_RUNNING;
      end

      reset_history_next = {reset_history[6:0], r};
      if (reset_history_next == HIST_HIT) begin
        reset_hit = 1'b1;
        for (int i = 0; i < MAX_LANES; i++) begin
          lane_ms_next[i]        = '0;
          lane_place_next[i]     = '0;
          finish_history_next[i] = '0;
        end
        lane_active_next   = '0;
        phase_next         = PHASE_IDLE;
        next_place_next    = FIRST_PLACE;
        start_history_next = '0;
        reset_history_next = '0;
      end

      // Lanes are scanned in order so that places go out lowest lane first.
      if (phase_next == PHASE_RUNNING) begin
        for (int i = 0; i < MAX_LANES; i++) begin
          if (LANE_EN[i]) begin
            a = finish_levels[i] ^ !finish_active_high;
            finish_history_next[i] = {finish_history[i][6:0], a};
            if (finish_history_next[i] == HIST_HIT && lane_active_next[i]) begin
              fin_set[i]          = 1'b1;
              lane_active_next[i] = 1'b0;
              if (next_place_next >= FIRST_PLACE && next_place_next <= LAST_PLACE) begin
                lane_place_next[i] = next_place_next;
                next_place_next    = next_place_next + 3'd1;
              end else begin
                next_place_next = NO_PLACE_LEFT;
              end
            end
          end
        end
        if (fin_set != '0 && lane_active_next == '0) begin
          phase_next = PHASE_FINISHED;
        end
      end
    end
  end

  always_comb begin
    push_rec          = '0;
    push_rec.start_ev = start_hit;
    push_rec.reset_ev = reset_hit;
    push_rec.fin_set  = fin_set;
    push_rec.phase    = phase_next;
    push_rec.mask     = lane_active_next & LANE_EN;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (LANE_EN[i]) begin
        push_rec.places[3*i +: 3]  = lane_place_next[i];
        push_rec.times[16*i +: 16] = lane_ms_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PHASE_IDLE;
      lane_active   <= '0;
      next_place    <= FIRST_PLACE;
      start_history <= '0;
      reset_history <= '0;
      for (int i = 0; i < MAX_LANES; i++) begin
        lane_ms[i]        <= '0;
        lane_place[i]     <= '0;
        finish_history[i] <= '0;
      end
    end else if (push) begin
      phase         <= phase_next;
      lane_active   <= lane_active_next;
      next_place    <= next_place_next;
      start_history <= start_history_next;
      reset_history <= reset_history_next;
      for (int i = 0; i < MAX_LANES; i++) begin
        lane_ms[i]        <= lane_ms_next[i];
        lane_place[i]     <= lane_place_next[i];
        finish_history[i] <= finish_history_next[i];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/mlrt_queue.sv]
`default_nettype none

module mlrt_queue import mlrt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire mlrt_rec_t push_rec,
  input  wire logic      pop,
  output logic           full,
  output logic           empty,
  output mlrt_rec_t      head
);

  mlrt_rec_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/mlrt_back.sv]
`default_nettype none

module mlrt_back import mlrt_pkg::*; #(
  parameter int LANE_COUNT = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   empty,
  input  wire mlrt_rec_t              head,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  event_kind,
  output logic [1:0]                  event_lane,
  output logic [15:0]                 event_time,
  output logic [2:0]                  event_place,
  output logic [1:0]                  race_phase,
  output logic [MAX_LANES-1:0]        running_mask,
  output logic [3*MAX_LANES-1:0]      places_packed,
  output logic [16*MAX_LANES-1:0]     times_packed,
  output logic                        last
);

  localparam logic [MAX_LANES-1:0] LANE_EN = MAX_LANES'((1 << LANE_COUNT) - 1);

  logic [EV_W-1:0] done;
  logic [EV_W-1:0] pend;
  logic [EV_W-1:0] sel;
  logic            load;

  logic [1:0]             kind_next;
  logic [1:0]             lane_next;
  logic [15:0]            time_next;
  logic [2:0]             place_next;
  logic [1:0]             phase_next;
  logic [MAX_LANES-1:0]   mask_next;
  logic [3*MAX_LANES-1:0] places_next;
  logic [16*MAX_LANES-1:0] times_next;
  logic                   last_next;

  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load && last_next;

  always_comb begin
    logic found;
    pend  = {head.fin_set, head.reset_ev, head.start_ev} & ~done;
    sel   = '0;
    found = 1'b0;
    for (int k = 0; k < EV_W; k++) begin
      if (pend[k] && !found) begin
        sel[k] = 1'b1;
        found  = 1'b1;
      end
    end

    kind_next   = KIND_NONE;
    lane_next   = '0;
    time_next   = '0;
    place_next  = '0;
    phase_next  = head.phase;
    mask_next   = head.mask;
    places_next = head.places;
    times_next  = head.times;

    if (sel[EV_START]) begin
      kind_next   = KIND_START;
      phase_next  = PHASE_RUNNING;
      mask_next   = LANE_EN;
      places_next = '0;
      times_next  = '0;
    end else if (sel[EV_RESET]) begin
      kind_next   = KIND_RESET;
      phase_next  = PHASE_IDLE;
      mask_next   = '0;
      places_next = '0;
      times_next  = '0;
    end else begin
      for (int i = 0; i < MAX_LANES; i++) begin
        if (sel[EV_LANE0 + i]) begin
          kind_next  = KIND_FINISH;
          lane_next  = 2'(i);
          time_next  = head.times[16*i +: 16];
          place_next = head.places[3*i +: 3];
          // Lanes that finish later in the same item still run here.
          for (int j = 0; j < MAX_LANES; j++) begin
            if (j > i && head.fin_set[j]) begin
              mask_next[j]          = 1'b1;
              places_next[3*j +: 3] = '0;
              phase_next            = PHASE_RUNNING;
            end
          end
        end
      end
    end

    last_next = (pend & ~sel) == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= last_next ? '0 : (done | sel);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_kind    <= kind_next;
      event_lane    <= lane_next;
      event_time    <= time_next;
      event_place   <= place_next;
      race_phase    <= phase_next;
      running_mask  <= mask_next;
      places_packed <= places_next;
      times_packed  <= times_next;
      last          <= last_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/multi_lane_race_timer.sv]
`default_nettype none

// Multi-lane race timer. Each input transaction is either a pin sample poll
// or a one millisecond tick; each produces one to five result transactions,
// the final one flagged by last, and each result carries a snapshot of the
// race state right after its event. The front end takes one input
// transaction per cycle while the queue has room and settles the whole
// state update for it in that cycle. A four-entry queue then hands the item
// to the back end, which sends one result per cycle through an output
// register while out_ready allows, so an item with several results holds
// the back end until its last result is loaded. With one result per item
// and out_ready held high the block sustains one transaction per cycle on
// both sides. The polarity registers are written through the configuration
// channel, which is always ready; write them only while the block is idle.

module multi_lane_race_timer import mlrt_pkg::*; #(
  parameter int LANE_COUNT = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Input item channel.
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    action,
  input  wire logic                    start_level,
  input  wire logic                    reset_level,
  input  wire logic [MAX_LANES-1:0]    finish_levels,
  // Result channel.
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   event_kind,
  output logic [1:0]                   event_lane,
  output logic [15:0]                  event_time,
  output logic [2:0]                   event_place,
  output logic [1:0]                   race_phase,
  output logic [MAX_LANES-1:0]         running_mask,
  output logic [3*MAX_LANES-1:0]       places_packed,
  output logic [16*MAX_LANES-1:0]      times_packed,
  output logic                         last,
  // Configuration write channel.
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [7:0]              cfg_index,
  input  wire logic [7:0]              cfg_data
);

  mlrt_rec_t push_rec;
  mlrt_rec_t head;
  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_empty;

  // The configuration channel is always ready.
  assign cfg_ready = 1'b1;

  // The front end debounces the pins, runs the timers and assigns places,
  // and pushes the events of each item together with the resulting state.
  mlrt_front #(
    .LANE_COUNT (LANE_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .start_level   (start_level),
    .reset_level   (reset_level),
    .finish_levels (finish_levels),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .queue_full    (queue_full),
    .push          (push),
    .push_rec      (push_rec)
  );

  mlrt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (queue_full),
    .empty    (queue_empty),
    .head     (head)
  );

  // The back end walks the events of the item at the queue head in order
  // (start, reset, then finishes by lane) and rebuilds each snapshot.
  mlrt_back #(
    .LANE_COUNT (LANE_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (queue_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .event_lane    (event_lane),
    .event_time    (event_time),
    .event_place   (event_place),
    .race_phase    (race_phase),
    .running_mask  (running_mask),
    .places_packed (places_packed),
    .times_packed  (times_packed),
    .last          (last)
  );

endmodule

`default_nettype wire

[bench/multi_lane_race_timer_test.sv]
`default_nettype none

// Self-checking bench for the multi-lane race timer.
//
// A driver process feeds input transactions from a queue of pending items,
// and a monitor process accepts result transactions. Both throttle their
// side at random. Whenever the driver sees an input transaction accepted it
// runs the bench's own race model on that item and appends every result the
// item should cause to a queue. The monitor compares each accepted result,
// field by field, with the oldest entry in that queue.
//
// The stimulus runs in four parts:
//   - A short directed part: a tick while idle, start and finish in the same
//     poll, a start press while running, a finish of a lane that already
//     stopped, a start from the finished phase together with a reset, and a
//     poll that starts a race and finishes all four lanes at once.
//   - A longer race with ticks before lane 0 finishes and more ticks before
//     the others finish. The monitor holds off for a long stretch around
//     this part so the block fills up and stalls its input.
//   - Random phases under every combination of the two polarity registers.
//     Most polls are well-formed press sequences (a run of inactive samples
//     with an occasional active one) so that presses and finishes happen
//     often; the rest are ticks and fully random polls.
//   - The last phase runs with no idling on either side.
// Registers are only written while nothing is pending or expected.

module multi_lane_race_timer_test;
  import mlrt_pkg::*;

  localparam int LANES = 4;
  // Timeout, far above the slowest legal run of about 270 items.
  localparam int CYCLE_LIMIT = 10_000_000;
  // Long receiver hold-off, started once enough results have been seen.
  localparam int HOLD_AFTER = 30;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 52;
  localparam int RACE_TICKS = 20;
  // A register index that names no register; writes to it must be dropped.
  localparam logic [7:0] CFG_OUT_OF_RANGE = CFG_FINISH_POL + 8'd1;

  // One input item, as offered on the input channel.
  typedef struct packed {
    logic                 action;
    logic                 start_level;
    logic                 reset_level;
    logic [MAX_LANES-1:0] finish_levels;
  } race_input_t;

  localparam int IN_W = $bits(race_input_t);

  // One result, as seen on the result channel.
  typedef struct packed {
    logic [1:0]              kind;
    logic [1:0]              lane;
    logic [15:0]             ms;
    logic [2:0]              place;
    logic [1:0]              phase;
    logic [MAX_LANES-1:0]    mask;
    logic [3*MAX_LANES-1:0]  places;
    logic [16*MAX_LANES-1:0] times;
    logic                    last;
  } race_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    action = ACTION_POLL;
  logic                    start_level = 1'b0;
  logic                    reset_level = 1'b0;
  logic [MAX_LANES-1:0]    finish_levels = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              event_kind;
  logic [1:0]              event_lane;
  logic [15:0]             event_time;
  logic [2:0]              event_place;
  logic [1:0]              race_phase;
  logic [MAX_LANES-1:0]    running_mask;
  logic [3*MAX_LANES-1:0]  places_packed;
  logic [16*MAX_LANES-1:0] times_packed;
  logic                    last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [7:0]              cfg_index = '0;
  logic [7:0]              cfg_data = '0;

  multi_lane_race_timer #(
    .LANE_COUNT(LANES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .start_level(start_level),
    .reset_level(reset_level),
    .finish_levels(finish_levels),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_kind(event_kind),
    .event_lane(event_lane),
    .event_time(event_time),
    .event_place(event_place),
    .race_phase(race_phase),
    .running_mask(running_mask),
    .places_packed(places_packed),
    .times_packed(times_packed),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Items waiting to be offered, and results the accepted items still owe.
  race_input_t  race_inputs_waiting[$];
  race_result_t race_events_due[$];

  int mismatches = 0;
  int results_seen = 0;
  int cycles_run = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  // Set for the final phase: no idling on either side from then on.
  bit calm = 1'b0;

  // ---------------------------------------------------------------------
  // Race model. It mirrors the block's state and polarity registers and is
  // advanced once for every accepted input transaction.
  // ---------------------------------------------------------------------
  logic       btn_hi;
  logic       fin_hi;
  logic [1:0] phase_now;
  logic [15:0] lap_ms [MAX_LANES];
  logic        lane_on [MAX_LANES];
  logic [2:0]  lane_rank [MAX_LANES];
  logic [2:0]  rank_next;
  logic [7:0]  start_shift;
  logic [7:0]  reset_shift;
  logic [7:0]  finish_shift [MAX_LANES];

  // Reset press: everything but the polarity registers goes back to idle.
  function automatic void clear_race();
    for (int i = 0; i < MAX_LANES; i++) begin
      lap_ms[i] = '0;
      lane_on[i] = 1'b0;
      lane_rank[i] = '0;
      finish_shift[i] = '0;
    end
    phase_now = PHASE_IDLE;
    rank_next = FIRST_PLACE;
    start_shift = '0;
    reset_shift = '0;
  endfunction

  // Builds one result from the race state as it stands right now.
  function automatic race_result_t race_snapshot(logic [1:0] kind, int lane,
                                                 logic [15:0] ms, logic [2:0] place);
    race_result_t res;
    res = '0;
    res.kind = kind;
    res.lane = lane[1:0];
    res.ms = ms;
    res.place = place;
    res.phase = phase_now;
    for (int i = 0; i < LANES; i++) begin
      res.mask[i] = lane_on[i];
      res.places[3*i +: 3] = lane_rank[i];
      res.times[16*i +: 16] = lap_ms[i];
    end
    return res;
  endfunction

  // Advances the race by one input item and queues the results it causes.
  function automatic void predict_race_events(race_input_t it);
    race_result_t batch [5];
    race_result_t tail;
    int           n;
    logic         s_act;
    logic         r_act;
    logic         f_act;
    logic         any_running;
    n = 0;
    if (it.action == ACTION_TICK) begin
      if (phase_now == PHASE_RUNNING) begin
        for (int i = 0; i < LANES; i++) begin
          if (lane_on[i]) lap_ms[i] = lap_ms[i] + 16'd1;
        end
      end
    end else begin
      // A pin is active when its raw level matches the polarity register.
      s_act = it.start_level ~^ btn_hi;
      r_act = it.reset_level ~^ btn_hi;

      start_shift = {start_shift[6:0], s_act};
      if (start_shift == HIST_HIT &&
          (phase_now == PHASE_IDLE || phase_now == PHASE_FINISHED)) begin
        for (int i = 0; i < MAX_LANES; i++) begin
          lap_ms[i] = '0;
          lane_on[i] = (i < LANES);
          lane_rank[i] = '0;
        end
        rank_next = FIRST_PLACE;
        phase_now = PHASE_RUNNING;
        batch[n] = race_snapshot(KIND_START, 0, '0, '0);
        n++;
      end

      reset_shift = {reset_shift[6:0], r_act};
      if (reset_shift == HIST_HIT) begin
        clear_race();
        batch[n] = race_snapshot(KIND_RESET, 0, '0, '0);
        n++;
      end

      // Finish sensors are only sampled while a race runs.
      if (phase_now == PHASE_RUNNING) begin
        for (int i = 0; i < LANES; i++) begin
          f_act = it.finish_levels[i] ~^ fin_hi;
          finish_shift[i] = {finish_shift[i][6:0], f_act};
          if (finish_shift[i] == HIST_HIT && phase_now == PHASE_RUNNING &&
              lane_on[i]) begin
            lane_on[i] = 1'b0;
            if (rank_next >= FIRST_PLACE && rank_next <= LAST_PLACE) begin
              lane_rank[i] = rank_next;
              rank_next = rank_next + 3'd1;
            end else begin
              rank_next = NO_PLACE_LEFT;
            end
            any_running = 1'b0;
            for (int j = 0; j < LANES; j++) begin
              if (lane_on[j]) any_running = 1'b1;
            end
            if (!any_running) phase_now = PHASE_FINISHED;
            batch[n] = race_snapshot(KIND_FINISH, i, lap_ms[i], lane_rank[i]);
            n++;
          end
        end
      end
    end

    // An item with no event still reports a snapshot.
    if (n == 0) begin
      batch[n] = race_snapshot(KIND_NONE, 0, '0, '0);
      n++;
    end
    tail = batch[n-1];
    tail.last = 1'b1;
    batch[n-1] = tail;
    for (int k = 0; k < n; k++) race_events_due.push_back(batch[k]);
  endfunction

  // ---------------------------------------------------------------------
  // Driver. The payload of the head item stays on the pins until the
  // transaction is taken; only then is the next item considered.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_race_events(race_inputs_waiting.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!calm && hold_left == 0 && $urandom_range(0, 7) == 0) begin
          // Start an idle burst; gap_left holds in_valid low until it runs out.
          gap_left <= $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (race_inputs_waiting.size() != 0) begin
          in_valid <= 1'b1;
          action <= race_inputs_waiting[0].action;
          start_level <= race_inputs_waiting[0].start_level;
          reset_level <= race_inputs_waiting[0].reset_level;
          finish_levels <= race_inputs_waiting[0].finish_levels;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor. It checks every accepted result and drives out_ready, with
  // short random stalls and one long hold-off.
  // ---------------------------------------------------------------------
  function automatic void compare_field(string what, logic [63:0] want,
                                        logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    race_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (race_events_due.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual kind %0h",
                   $time, event_kind);
          mismatches++;
        end else begin
          want = race_events_due.pop_front();
          compare_field("event_kind", 64'(want.kind), 64'(event_kind));
          compare_field("event_lane", 64'(want.lane), 64'(event_lane));
          compare_field("event_time", 64'(want.ms), 64'(event_time));
          compare_field("event_place", 64'(want.place), 64'(event_place));
          compare_field("race_phase", 64'(want.phase), 64'(race_phase));
          compare_field("running_mask", 64'(want.mask), 64'(running_mask));
          compare_field("places_packed", 64'(want.places), 64'(places_packed));
          compare_field("times_packed", want.times, times_packed);
          compare_field("last", 64'(want.last), 64'(last));
        end
      end

      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        // Long back-pressure: the block's queue fills and in_ready drops.
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic logic one_in(int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  // A tick; the pin fields carry random values that the block must ignore.
  function automatic void queue_tick();
    race_input_t it;
    it = IN_W'($urandom);
    it.action = ACTION_TICK;
    race_inputs_waiting.push_back(it);
  endfunction

  // A poll given as active flags, turned into raw levels by the current
  // polarity settings.
  function automatic void queue_poll(logic st, logic rs, logic [MAX_LANES-1:0] fin);
    race_input_t it;
    it.action = ACTION_POLL;
    it.start_level = st ~^ btn_hi;
    it.reset_level = rs ~^ btn_hi;
    it.finish_levels = fin ~^ {MAX_LANES{fin_hi}};
    race_inputs_waiting.push_back(it);
  endfunction

  function automatic void queue_quiet_polls(int count);
    for (int k = 0; k < count; k++) queue_poll(1'b0, 1'b0, '0);
  endfunction

  function automatic void queue_random_items(int count);
    race_input_t          it;
    int                   roll;
    logic [MAX_LANES-1:0] fin;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        queue_tick();
      end else if (roll < 50) begin
        // Noise: any raw levels at all.
        it = IN_W'($urandom);
        it.action = ACTION_POLL;
        race_inputs_waiting.push_back(it);
      end else begin
        // Mostly inactive samples with sparse active ones, so that pins
        // often see seven quiet samples before a press.
        for (int i = 0; i < MAX_LANES; i++) fin[i] = one_in(10);
        queue_poll(one_in(6), one_in(30), fin);
      end
    end
  endfunction

  // Waits until every item has been taken and every result has arrived.
  task automatic wait_until_idle();
    while (race_inputs_waiting.size() != 0 || race_events_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [7:0] idx, logic value);
    logic [7:0] pad;
    pad = 8'($urandom_range(0, 127));
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    // Only bit 0 counts; the upper bits get random filler.
    cfg_data <= {pad[6:0], value};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_BUTTON_POL) begin
      btn_hi = value;
    end else if (idx == CFG_FINISH_POL) begin
      fin_hi = value;
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    btn_hi = 1'b0;
    fin_hi = 1'b0;
    clear_race();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_reg(CFG_BUTTON_POL, 1'b0);
    write_reg(CFG_FINISH_POL, 1'b0);

    @(negedge clk);
    // Directed part. Histories are clear after reset, so one active sample
    // counts as a press.
    queue_tick();                          // tick while idle: plain snapshot
    queue_poll(1'b1, 1'b0, 4'b0001);       // start, and lane 0 finishes at once
    queue_tick();
    queue_tick();
    queue_quiet_polls(7);
    queue_poll(1'b1, 1'b0, 4'b1111);       // start ignored while running; lane 0
                                           // already stopped; lanes 1-3 finish
    queue_quiet_polls(7);
    queue_poll(1'b1, 1'b1, 4'b1111);       // start from finished, then reset
    queue_poll(1'b1, 1'b0, 4'b1111);       // start and all four finish together

    // A longer race: lane 0 finishes after a run of ticks, the others a few
    // ticks later.
    queue_quiet_polls(7);
    queue_poll(1'b1, 1'b0, 4'b0000);
    for (int k = 0; k < RACE_TICKS; k++) queue_tick();
    queue_quiet_polls(6);
    queue_poll(1'b0, 1'b0, 4'b0001);
    repeat (3) queue_tick();
    queue_poll(1'b0, 1'b0, 4'b1110);
    wait_until_idle();

    // A write to an index that names no register changes nothing.
    write_reg(CFG_OUT_OF_RANGE, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      wait_until_idle();
      write_reg(CFG_BUTTON_POL, (ph == 0 || ph == 1));
      write_reg(CFG_FINISH_POL, (ph == 0 || ph == 2));
      @(negedge clk);
      if (ph == 3) calm = 1'b1;
      queue_random_items(ITEMS_PER_PHASE);
    end

    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
